// ----- hdl/psic_pkg.sv -----
// Package for the pressure/temperature compensation block: widths, codes and shared types.
package psic_pkg;

  // Port and register widths
  localparam int unsigned RAW_W  = 20;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 64;

  // Datapath widths for the divider
  localparam int unsigned NUM_W = 76;             // |b| * 3125
  localparam int unsigned DEN_W = 40;             // |divisor|
  localparam int unsigned QUO_W = 37;             // quotient bits below overflow

  // Quotient saturation level, 2^36
  localparam logic [QUO_W-1:0] QUOT_LIMIT = 37'h10_0000_0000;

  // Cycles from an accepted transaction to its result strobe
  localparam int unsigned LATENCY = 53;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RAW_ZERO = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TEMP_CAL   = 2'd0,
    REG_PRESS_A    = 2'd1,
    REG_PRESS_B    = 2'd2,
    REG_PRESS_LAST = 2'd3
  } reg_idx_t;

  // Flags and temperature carried alongside the divider
  typedef struct packed {
    logic               raw_zero;
    logic               div_zero;
    logic               neg;
    logic signed [15:0] temp;
  } psic_side_t;

endpackage

// ----- hdl/pressure_sensor_int_compensation.sv -----
// An accepted transaction runs through the front stages, the divider and the back stages; done marks its result.
// Throughput: one transaction per cycle; busy never rises. The 37-stage divider (one
// quotient bit per stage) sets most of the latency; every stage takes new data each cycle.
// Reset (rst, synchronous) clears all valid bits and the calibration registers to zero.
// Results cannot be held off by the receiver.
module pressure_sensor_int_compensation import psic_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         raw_pressure,
  input  logic [RAW_W-1:0]         raw_temperature,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [15:0]       temperature_centi,
  output logic [31:0]              pressure_q24_8
);

  // ---------------- configuration ----------------
  logic [47:0]        temp_cal_words;
  logic [63:0]        press_cal_words_a;
  logic [63:0]        press_cal_words_b;
  logic signed [15:0] press_cal_last;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal_words    <= '0;
      press_cal_words_a <= '0;
      press_cal_words_b <= '0;
      press_cal_last    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP_CAL:   temp_cal_words    <= pwdata[47:0];
        REG_PRESS_A:    press_cal_words_a <= pwdata;
        REG_PRESS_B:    press_cal_words_b <= pwdata;
        REG_PRESS_LAST: press_cal_last    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEMP_CAL:   prdata = {16'd0, temp_cal_words};
      REG_PRESS_A:    prdata = press_cal_words_a;
      REG_PRESS_B:    prdata = press_cal_words_b;
      REG_PRESS_LAST: prdata = {48'd0, press_cal_last};
    endcase
  end

  // Calibration coefficients
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cal_words[15:0];
  assign t2 = $signed(temp_cal_words[31:16]);
  assign t3 = $signed(temp_cal_words[47:32]);
  assign p1 = press_cal_words_a[15:0];
  assign p2 = $signed(press_cal_words_a[31:16]);
  assign p3 = $signed(press_cal_words_a[47:32]);
  assign p4 = $signed(press_cal_words_a[63:48]);
  assign p5 = $signed(press_cal_words_b[15:0]);
  assign p6 = $signed(press_cal_words_b[31:16]);
  assign p7 = $signed(press_cal_words_b[47:32]);
  assign p8 = $signed(press_cal_words_b[63:48]);
  assign p9 = press_cal_last;

  // ---------------- stage 1: temperature products ----------------
  logic signed [18:0] c1_diff;
  logic signed [16:0] c1_d;
  logic signed [33:0] c1_dd;
  logic               s1_valid, s1_zr;
  logic signed [34:0] s1_m1;
  logic [31:0]        s1_dd;
  logic [RAW_W-1:0]   s1_adcp;

  assign c1_diff = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
  assign c1_d    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign c1_dd   = c1_d * c1_d;

  always_ff @(posedge clk) begin
    s1_m1   <= c1_diff * t2;
    s1_dd   <= c1_dd[31:0];
    s1_adcp <= raw_pressure;
    s1_zr   <= (raw_pressure == '0) || (raw_temperature == '0);
  end

  // ---------------- stage 2 ----------------
  logic signed [34:0] c2_sh;
  logic               s2_valid, s2_zr;
  logic signed [23:0] s2_v1;
  logic signed [36:0] s2_m2;
  logic [RAW_W-1:0]   s2_adcp;

  assign c2_sh = s1_m1 >>> 11;

  always_ff @(posedge clk) begin
    s2_v1   <= c2_sh[23:0];
    s2_m2   <= $signed({1'b0, s1_dd[31:12]}) * t3;
    s2_adcp <= s1_adcp;
    s2_zr   <= s1_zr;
  end

  // ---------------- stage 3: t_fine ----------------
  logic signed [36:0] c3_sh;
  logic signed [22:0] c3_v2;
  logic               s3_valid, s3_zr;
  logic signed [23:0] s3_tfine;
  logic [RAW_W-1:0]   s3_adcp;

  assign c3_sh = s2_m2 >>> 14;
  assign c3_v2 = c3_sh[22:0];

  always_ff @(posedge clk) begin
    s3_tfine <= s2_v1 + c3_v2;
    s3_adcp  <= s2_adcp;
    s3_zr    <= s2_zr;
  end

  // ---------------- stage 4: temperature out, offset ----------------
  logic signed [26:0] c4_t5, c4_tc;
  logic signed [15:0] c4_temp;
  logic               s4_valid, s4_zr;
  logic signed [23:0] s4_x;
  logic signed [15:0] s4_temp;
  logic [RAW_W-1:0]   s4_adcp;

  assign c4_t5 = (s3_tfine * 27'sd5) + 27'sd128;
  assign c4_tc = c4_t5 >>> 8;

  always_comb begin
    priority if (c4_tc > 27'sd32767)  c4_temp = 16'sh7fff;
    else if (c4_tc < -27'sd32768)     c4_temp = 16'sh8000;
    else                              c4_temp = c4_tc[15:0];
  end

  always_ff @(posedge clk) begin
    s4_temp <= c4_temp;
    s4_x    <= s3_tfine - 24'sd128000;
    s4_adcp <= s3_adcp;
    s4_zr   <= s3_zr;
  end

  // ---------------- stage 5: x products ----------------
  logic signed [47:0] c5_xx;
  logic               s5_valid, s5_zr;
  logic [44:0]        s5_xx;
  logic signed [39:0] s5_xp5, s5_xp2;
  logic signed [15:0] s5_temp;
  logic [RAW_W-1:0]   s5_adcp;

  assign c5_xx = s4_x * s4_x;

  always_ff @(posedge clk) begin
    s5_xx   <= c5_xx[44:0];
    s5_xp5  <= s4_x * p5;
    s5_xp2  <= s4_x * p2;
    s5_temp <= s4_temp;
    s5_adcp <= s4_adcp;
    s5_zr   <= s4_zr;
  end

  // ---------------- stage 6: x^2 products ----------------
  logic               s6_valid, s6_zr;
  logic signed [61:0] s6_xxp6, s6_xxp3;
  logic signed [39:0] s6_xp5, s6_xp2;
  logic signed [15:0] s6_temp;
  logic [RAW_W-1:0]   s6_adcp;

  always_ff @(posedge clk) begin
    s6_xxp6 <= $signed({1'b0, s5_xx}) * p6;
    s6_xxp3 <= $signed({1'b0, s5_xx}) * p3;
    s6_xp5  <= s5_xp5;
    s6_xp2  <= s5_xp2;
    s6_temp <= s5_temp;
    s6_adcp <= s5_adcp;
    s6_zr   <= s5_zr;
  end

  // ---------------- stage 7: polynomial sums ----------------
  logic signed [61:0] c7_xs;
  logic               s7_valid, s7_zr;
  logic signed [63:0] s7_v2;
  logic signed [55:0] s7_a;
  logic signed [15:0] s7_temp;
  logic [RAW_W-1:0]   s7_adcp;

  assign c7_xs = s6_xxp3 >>> 8;

  always_ff @(posedge clk) begin
    s7_v2   <= 64'(s6_xxp6) + (64'(s6_xp5) <<< 17) + (64'(p4) <<< 35);
    s7_a    <= 56'(c7_xs) + (56'(s6_xp2) <<< 12) + 56'sd140737488355328;
    s7_temp <= s6_temp;
    s7_adcp <= s6_adcp;
    s7_zr   <= s6_zr;
  end

  // ---------------- stage 8: divisor partial products, dividend ----------------
  logic [20:0]        c8_span;
  logic signed [64:0] c8_b;
  logic               s8_valid, s8_zr;
  logic signed [44:0] s8_ph;
  logic [43:0]        s8_pl;
  logic signed [64:0] s8_b;
  logic signed [15:0] s8_temp;

  assign c8_span = 21'h10_0000 - {1'b0, s7_adcp};
  assign c8_b    = $signed({13'd0, c8_span, 31'd0}) - 65'(s7_v2);

  always_ff @(posedge clk) begin
    s8_ph   <= $signed(s7_a[55:28]) * $signed({1'b0, p1});
    s8_pl   <= s7_a[27:0] * p1;
    s8_b    <= c8_b;
    s8_temp <= s7_temp;
    s8_zr   <= s7_zr;
  end

  // ---------------- stage 9: divisor, dividend magnitude ----------------
  logic signed [72:0] c9_prod;
  logic               s9_valid, s9_zr, s9_bneg;
  logic signed [39:0] s9_div;
  logic [63:0]        s9_mb;
  logic signed [15:0] s9_temp;

  assign c9_prod = (73'(s8_ph) <<< 28) + $signed({29'd0, s8_pl});

  always_ff @(posedge clk) begin
    s9_div  <= c9_prod[72:33];
    s9_mb   <= s8_b[64] ? 64'(-s8_b) : 64'(s8_b);
    s9_bneg <= s8_b[64];
    s9_temp <= s8_temp;
    s9_zr   <= s8_zr;
  end

  // ---------------- stage 10: scaled numerator, divisor magnitude ----------------
  logic               s10_valid;
  logic [NUM_W-1:0]   s10_num;
  logic [DEN_W-1:0]   s10_md;
  psic_side_t         s10_side;

  always_ff @(posedge clk) begin
    s10_num           <= s9_mb * 12'd3125;
    s10_md            <= s9_div[39] ? DEN_W'(-s9_div) : DEN_W'(s9_div);
    s10_side.raw_zero <= s9_zr;
    s10_side.div_zero <= (s9_div == '0);
    s10_side.neg      <= s9_bneg ^ s9_div[39];
    s10_side.temp     <= s9_temp;
  end

  // Valid bits for the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      s10_valid <= 1'b0;
    end else begin
      s1_valid  <= start & ~busy;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      s9_valid  <= s8_valid;
      s10_valid <= s9_valid;
    end
  end

  // ---------------- divider ----------------
  logic             dv_valid, dv_sat;
  logic [QUO_W-1:0] dv_quo;
  psic_side_t       dv_side;

  psic_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s10_valid),
    .num       (s10_num),
    .den       (s10_md),
    .in_side   (s10_side),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .sat       (dv_sat),
    .out_side  (dv_side)
  );

  // ---------------- post 1: saturate and sign the quotient ----------------
  logic [QUO_W-1:0]   c_q;
  logic               u1_valid;
  logic signed [37:0] u1_p;
  psic_side_t         u1_side;

  assign c_q = (dv_sat || (dv_quo > QUOT_LIMIT)) ? QUOT_LIMIT : dv_quo;

  always_ff @(posedge clk) begin
    u1_p    <= dv_side.neg ? -$signed({1'b0, c_q}) : $signed({1'b0, c_q});
    u1_side <= dv_side;
  end

  // ---------------- post 2: square and P8 term ----------------
  logic signed [49:0] c_sq;
  logic               u2_valid;
  logic [46:0]        u2_sq;
  logic signed [53:0] u2_pp8;
  logic signed [37:0] u2_p;
  psic_side_t         u2_side;

  assign c_sq = $signed(u1_p[37:13]) * $signed(u1_p[37:13]);

  always_ff @(posedge clk) begin
    u2_sq   <= c_sq[46:0];
    u2_pp8  <= u1_p * p8;
    u2_p    <= u1_p;
    u2_side <= u1_side;
  end

  // ---------------- post 3: P9 term ----------------
  logic               u3_valid;
  logic signed [63:0] u3_s9;
  logic signed [34:0] u3_v2;
  logic signed [37:0] u3_p;
  psic_side_t         u3_side;

  always_ff @(posedge clk) begin
    u3_s9   <= $signed({1'b0, u2_sq}) * p9;
    u3_v2   <= u2_pp8[53:19];
    u3_p    <= u2_p;
    u3_side <= u2_side;
  end

  // ---------------- post 4: correction sum ----------------
  logic signed [38:0] c_v1;
  logic               u4_valid;
  logic signed [40:0] u4_sum;
  psic_side_t         u4_side;

  assign c_v1 = u3_s9[63:25];

  always_ff @(posedge clk) begin
    u4_sum  <= 41'(u3_p) + 41'(c_v1) + 41'(u3_v2);
    u4_side <= u3_side;
  end

  // ---------------- output: offset, clamp, status ----------------
  logic signed [32:0] c_shr;
  logic signed [33:0] c_r;
  logic [31:0]        c_pres;

  assign c_shr = u4_sum[40:8];
  assign c_r   = 34'(c_shr) + (34'(p7) <<< 4);

  always_comb begin
    priority if (c_r[33])          c_pres = '0;
    else if (c_r[32])              c_pres = 32'hffff_ffff;
    else                           c_pres = c_r[31:0];
  end

  always_ff @(posedge clk) begin
    priority if (u4_side.raw_zero) begin
      status            <= ST_RAW_ZERO;
      temperature_centi <= '0;
      pressure_q24_8    <= '0;
    end else if (u4_side.div_zero) begin
      status            <= ST_DIV_ZERO;
      temperature_centi <= u4_side.temp;
      pressure_q24_8    <= '0;
    end else begin
      status            <= ST_OK;
      temperature_centi <= u4_side.temp;
      pressure_q24_8    <= c_pres;
    end
  end

  // Valid bits for the back stages
  always_ff @(posedge clk) begin
    if (rst) begin
      u1_valid <= 1'b0;
      u2_valid <= 1'b0;
      u3_valid <= 1'b0;
      u4_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      u1_valid <= dv_valid;
      u2_valid <= u1_valid;
      u3_valid <= u2_valid;
      u4_valid <= u3_valid;
      done     <= u4_valid;
    end
  end

endmodule

// ----- hdl/psic_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module psic_div import psic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  psic_side_t       in_side,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic             sat,
  output psic_side_t       out_side
);

  logic             vld  [0:QUO_W];
  logic [DEN_W-1:0] rem  [0:QUO_W];
  logic [QUO_W-1:0] qs   [0:QUO_W];
  logic [DEN_W-1:0] dvs  [0:QUO_W];
  logic             ovf  [0:QUO_W];
  psic_side_t       sd   [0:QUO_W];

  logic [DEN_W:0]   trial    [0:QUO_W-1];
  logic             ge       [0:QUO_W-1];
  logic [DEN_W-1:0] rem_next [0:QUO_W-1];

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= QUO_W; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int i = 0; i < QUO_W; i++) vld[i+1] <= vld[i];
    end
  end

  // Entry: high part as starting remainder; quotient too big if it already reaches den
  always_ff @(posedge clk) begin
    rem[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
    qs[0]  <= num[QUO_W-1:0];
    dvs[0] <= den;
    ovf[0] <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
    sd[0]  <= in_side;
  end

  // One compare/subtract per stage
  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      trial[i]    = {rem[i], qs[i][QUO_W-1]};
      ge[i]       = trial[i] >= {1'b0, dvs[i]};
      rem_next[i] = ge[i] ? DEN_W'(trial[i] - {1'b0, dvs[i]}) : trial[i][DEN_W-1:0];
    end
  end

  // Numerator bits shift out as quotient bits shift in
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUO_W; i++) begin
      rem[i+1] <= rem_next[i];
      qs[i+1]  <= {qs[i][QUO_W-2:0], ge[i]};
      dvs[i+1] <= dvs[i];
      ovf[i+1] <= ovf[i];
      sd[i+1]  <= sd[i];
    end
  end

  assign out_valid = vld[QUO_W];
  assign quo       = qs[QUO_W];
  assign sat       = ovf[QUO_W];
  assign out_side  = sd[QUO_W];

endmodule

// ----- hdl/psic_checker.sv -----
// Port-level checker for the compensation block, bound to the top level.
module psic_checker import psic_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [RAW_W-1:0]   raw_pressure,
  input logic [RAW_W-1:0]   raw_temperature,
  input logic [1:0]         status,
  input logic signed [15:0] temperature_centi,
  input logic [31:0]        pressure_q24_8
);

  // Every accepted transaction yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted transaction");

  // No result without a transaction accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // Any error status carries a zero pressure
  a_err_pressure: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> (pressure_q24_8 == '0))
    else $error("nonzero pressure with error status");

  // A zero raw input reports raw-zero status with zero temperature
  a_raw_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (raw_pressure == '0 || raw_temperature == '0)) |->
      ##LATENCY (done && status == ST_RAW_ZERO && temperature_centi == '0))
    else $error("raw zero not reported");

endmodule

bind pressure_sensor_int_compensation psic_checker u_psic_checker (.*);

// ----- test/tb.sv -----
// Self-checking testbench for the pressure/temperature integer compensation block.
`timescale 1ns / 1ps

module tb;
  import psic_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
  } sample_t;

  typedef struct {
    status_t            st;
    logic signed [15:0] temp;
    logic [31:0]        press;
  } reading_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [RAW_W-1:0]    raw_pressure;
  logic [RAW_W-1:0]    raw_temperature;
  logic                done;
  logic [1:0]          status;
  logic signed [15:0]  temperature_centi;
  logic [31:0]         pressure_q24_8;

  // Calibration copy held by the predictor
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_p9;

  sample_t  samples_q[$];
  reading_t readings_q[$];
  int       error_cnt;
  int       stall_cnt;
  bit       hold_sender;
  bit       gaps_on;

  pressure_sensor_int_compensation u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .raw_pressure, .raw_temperature,
    .done, .status, .temperature_centi, .pressure_q24_8
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic wide_t sx16(logic [15:0] v);
    return wide_t'($signed(v));
  endfunction

  // Compensated reading for one raw sample under the current calibration
  function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt);
    reading_t r;
    wide_t adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    wide_t v1, v2, d, tfine, tmp, x, dv, b, p;
    logic [127:0] mb, md, qb, rb, q;
    bit neg;
    r.st = ST_OK;
    r.temp = '0;
    r.press = '0;
    if (rp == 0 || rt == 0) begin
      r.st = ST_RAW_ZERO;
      return r;
    end
    adc_p = wide_t'(rp);
    adc_t = wide_t'(rt);
    t1 = wide_t'(cal_temp[15:0]);
    t2 = sx16(cal_temp[31:16]);
    t3 = sx16(cal_temp[47:32]);
    p1 = wide_t'(cal_press_a[15:0]);
    p2 = sx16(cal_press_a[31:16]);
    p3 = sx16(cal_press_a[47:32]);
    p4 = sx16(cal_press_a[63:48]);
    p5 = sx16(cal_press_b[15:0]);
    p6 = sx16(cal_press_b[31:16]);
    p7 = sx16(cal_press_b[47:32]);
    p8 = sx16(cal_press_b[63:48]);
    p9 = sx16(cal_p9);

    // Temperature and fine temperature
    v1 = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
    d = (adc_t >>> 4) - t1;
    v2 = (((d * d) >>> 12) * t3) >>> 14;
    tfine = v1 + v2;
    tmp = (tfine * 5 + 128) >>> 8;
    if (tmp > 32767) tmp = 32767;
    if (tmp < -32768) tmp = -32768;
    r.temp = tmp[15:0];

    // Pressure divisor
    x = tfine - 128000;
    v2 = x * x * p6 + x * p5 * 131072 + p4 * (wide_t'(1) <<< 35);
    v1 = ((x * x * p3) >>> 8) + x * p2 * 4096;
    dv = (((wide_t'(1) <<< 47) + v1) * p1) >>> 33;
    if (dv == 0) begin
      r.st = ST_DIV_ZERO;
      return r;
    end

    // Signed division with quotient saturation
    b = (1048576 - adc_p) * (wide_t'(1) <<< 31) - v2;
    neg = (b < 0) != (dv < 0);
    mb = (b < 0) ? -b : b;
    md = (dv < 0) ? -dv : dv;
    qb = mb / md;
    rb = mb % md;
    if (qb >= (128'd1 << 36)) q = 128'd1 << 36;
    else q = qb * 3125 + (rb * 3125) / md;
    if (q > (128'd1 << 36)) q = 128'd1 << 36;
    p = neg ? -wide_t'(q) : wide_t'(q);

    // Second-order correction and output clamp
    v1 = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
    v2 = (p8 * p) >>> 19;
    p = ((p + v1 + v2) >>> 8) + p7 * 16;
    if (p < 0) p = 0;
    if (p > 64'd4294967295) p = 64'd4294967295;
    r.press = p[31:0];
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_cnt++;
  endtask

  // Driver: one transaction per accepted start
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        readings_q.push_back(compensate(raw_pressure, raw_temperature));
      if (start && busy) begin
        start <= 1'b1;
      end else if (samples_q.size() > 0 && !hold_sender &&
                   !(gaps_on && $urandom_range(99) < 6)) begin
        sample_t s;
        s = samples_q.pop_front();
        start <= 1'b1;
        raw_pressure <= s.raw_p;
        raw_temperature <= s.raw_t;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (readings_q.size() == 0) begin
        $display("%0t: result with no transaction pending", $realtime);
        error_cnt++;
      end else begin
        reading_t e;
        e = readings_q.pop_front();
        if (status !== e.st) report("status", status, e.st);
        if (temperature_centi !== e.temp)
          report("temperature_centi", temperature_centi, e.temp);
        if (pressure_q24_8 !== e.press) report("pressure_q24_8", pressure_q24_8, e.press);
      end
    end
  end

  // Watchdog on cycles with no progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 4000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 3;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TEMP_CAL:   cal_temp = val[47:0];
      REG_PRESS_A:    cal_press_a = val;
      REG_PRESS_B:    cal_press_b = val;
      REG_PRESS_LAST: cal_p9 = val[15:0];
    endcase
  endtask

  task automatic load_cal(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb, logic [15:0] p9);
    cfg_write(REG_TEMP_CAL, {16'd0, tc});
    cfg_write(REG_PRESS_A, pa);
    cfg_write(REG_PRESS_B, pb);
    cfg_write(REG_PRESS_LAST, {48'd0, p9});
  endtask

  task automatic add_sample(logic [19:0] rp, logic [19:0] rt);
    sample_t s;
    s.raw_p = rp;
    s.raw_t = rt;
    samples_q.push_back(s);
  endtask

  // Wait until the pipeline has drained
  task automatic drain();
    while (samples_q.size() > 0 || readings_q.size() > 0 || start) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    start = 1'b0;
    raw_pressure = '0;
    raw_temperature = '0;
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_p9 = '0;
    error_cnt = 0;
    stall_cnt = 0;
    hold_sender = 1'b0;
    gaps_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unloaded calibration: divisor is zero
    add_sample(20'd415148, 20'd519888);
    add_sample(20'hFFFFF, 20'hFFFFF);
    add_sample(20'd0, 20'd519888);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_cal({16'hFC18, 16'd26435, 16'd27504},
                    {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                    {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
        1: load_cal('0, '0, '0, '0);
        2: load_cal('1, '1, '1, '1);
        3: load_cal({16'h8000, 16'h8000, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
                    {4{16'h8000}}, 16'h8000);
        4: load_cal({16'h7FFF, 16'h7FFF, 16'h0000}, {{3{16'h7FFF}}, 16'h0001},
                    {4{16'h7FFF}}, 16'h7FFF);
        default: load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                          {$urandom, $urandom}, 16'($urandom));
      endcase
      gaps_on = (ph != 3);
      hold_sender = 1'b1;

      if (ph == 0) begin
        // Field extremes and zero raw values
        add_sample(20'd0, 20'd0);
        add_sample(20'd0, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'd0);
        add_sample(20'd1, 20'd1);
        add_sample(20'hFFFFF, 20'hFFFFF);
        add_sample(20'd1, 20'hFFFFF);
        add_sample(20'hFFFFF, 20'd1);
        add_sample(20'd415148, 20'd519888);
        add_sample(20'h55555, 20'hAAAAA);
        add_sample(20'hAAAAA, 20'h55555);
        add_sample(20'd300000, 20'd400000);
        add_sample(20'd600000, 20'd600000);
      end

      for (int i = 0; i < 175; i++) begin
        logic [19:0] rp, rt;
        case ($urandom_range(3))
          0: begin
            rp = 20'($urandom);
            rt = 20'($urandom);
          end
          1: begin
            rp = 20'($urandom_range(600000, 200000));
            rt = 20'($urandom_range(650000, 400000));
          end
          2: begin
            rp = 20'(1 << $urandom_range(19));
            rt = ~20'(1 << $urandom_range(19));
          end
          default: begin
            rp = ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom);
            rt = ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom);
          end
        endcase
        add_sample(rp, rt);
      end
      hold_sender = 1'b0;
      drain();
    end

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
